@@ rtl/lru_block_cache_writeback_assert.svh @@
// Assertion macros for the LRU block cache.
`ifndef LRU_BLOCK_CACHE_WRITEBACK_ASSERT_SVH
`define LRU_BLOCK_CACHE_WRITEBACK_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define LBCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define LBCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lbcw_pkg.sv @@
package lbcw_pkg;

    localparam int TAG_W           = 32;
    localparam int CFG_W           = 9;
    localparam int SLOT_W          = 8;
    localparam int CNT_W           = 32;
    localparam int DEF_MAX_BLOCKS  = 256;
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    typedef struct packed {
        logic             op;
        logic [TAG_W-1:0] block_number;
        logic             last_block;
    } t_in;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] cache_slot;
        logic              cache_is_write;
        logic              disk_fetch;
        logic              writeback_valid;
        logic [TAG_W-1:0]  writeback_block;
        logic [CNT_W-1:0]  read_hits;
        logic [CNT_W-1:0]  write_hits;
        logic [CNT_W-1:0]  cache_writes;
        logic              request_done;
    } t_out;

    // Word moving down the chain of recency cells.
    typedef struct packed {
        logic             act;
        logic             done;
        logic             hit;
        logic             hit_dirty;
        logic             dirty;
        logic             wb_valid;
        logic [TAG_W-1:0] tag;
        logic [TAG_W-1:0] wb_tag;
    } t_wave;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic [TAG_W-1:0] key;
        logic             fix_en;
        logic             fix_dirty;
        logic             trunc_en;
    } t_cmd;

endpackage

@@ rtl/lbcw_cell.sv @@
module lbcw_cell #(
    parameter int MAX_BLOCKS = lbcw_pkg::DEF_MAX_BLOCKS,
    parameter int IDX        = 0,
    localparam int LIM_W     = $clog2(MAX_BLOCKS + 2)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbcw_pkg::t_wave   i_wave,
    input  lbcw_pkg::t_cmd    i_cmd,
    input  logic [LIM_W-1:0]  i_lim,
    output lbcw_pkg::t_wave   o_wave
);
    import lbcw_pkg::*;

    logic             r_valid;
    logic             r_dirty;
    logic [TAG_W-1:0] r_tag;
    t_wave            r_out;

    logic             n_valid;
    logic             n_dirty;
    logic [TAG_W-1:0] n_tag;
    t_wave            n_out;
    logic             w_match;
    logic             w_tail;
    logic             w_trunc;

    assign w_match = r_valid && (r_tag == i_cmd.key);
    // old entry at this position falls out of the list on a miss
    assign w_tail  = (LIM_W'(IDX + 1) >= i_lim);
    assign w_trunc = (LIM_W'(IDX) >= i_lim);

    always_comb begin
        n_valid = r_valid;
        n_dirty = r_dirty;
        n_tag   = r_tag;
        n_out   = i_wave;
        if (i_wave.act && !i_wave.done) begin
            n_valid = 1'b1;
            n_tag   = i_wave.tag;
            n_dirty = i_wave.dirty;
            if (w_match) begin
                n_out.done      = 1'b1;
                n_out.hit       = 1'b1;
                n_out.hit_dirty = r_dirty;
            end else if (!r_valid) begin
                n_out.done = 1'b1;
                n_out.hit  = 1'b0;
            end else begin
                n_out.tag   = r_tag;
                n_out.dirty = r_dirty;
                if (r_dirty && w_tail) begin
                    n_out.wb_valid = 1'b1;
                    n_out.wb_tag   = r_tag;
                end
            end
        end
        if (i_cmd.trunc_en && w_trunc) begin
            n_valid = 1'b0;
            n_dirty = 1'b0;
        end
        if (i_cmd.fix_en && (IDX == 0)) begin
            n_dirty = i_cmd.fix_dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_out   <= '0;
        end else begin
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_out   <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

    assign o_wave = r_out;

endmodule

@@ rtl/lbcw_mod.sv @@
module lbcw_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lbcw_pkg::TAG_W-1:0] i_dividend,
    input  logic [lbcw_pkg::CFG_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [lbcw_pkg::CFG_W-1:0] o_rem
);
    import lbcw_pkg::*;

    localparam int IDX_W = $clog2(TAG_W);

    logic             r_busy;
    logic [IDX_W-1:0] r_cnt;
    logic [TAG_W-1:0] r_dvd;
    logic [CFG_W-1:0] r_div;
    logic [CFG_W-1:0] r_rem;

    logic [CFG_W:0]   w_trial;
    logic [CFG_W-1:0] n_rem;

    // restoring remainder, one dividend bit per cycle
    assign w_trial = {r_rem, r_dvd[TAG_W-1]};

    always_comb begin
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = CFG_W'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = w_trial[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= IDX_W'(TAG_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TAG_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = !r_busy;
    assign o_rem  = r_rem;

endmodule

@@ rtl/lru_block_cache_writeback.sv @@
// Fully associative LRU block cache with write-back, in front of a disk.
// Command channel: present one block access on i_cmd (op, block_number,
// last_block) with start high; it is taken at a clock edge where busy is
// low. Exactly one result per access appears on o_res for one cycle,
// marked by o_res_valid; the receiver cannot stall and must take it then.
// Flow: the access word walks the recency chain, one cell per cycle,
// and the slot address comes from a bit-serial remainder unit. The
// strobe comes once both are through; busy is high until then and a new
// access may be presented in the strobe cycle.
// Capacity: one write word on i_cfg_data, taken when i_cfg_valid and
// o_cfg_ready are high; o_cfg_ready is low while an access is in flight.
// Reset (synchronous, active low) empties the cache, clears the counters
// and sets the capacity to 256 blocks.
module lru_block_cache_writeback #(
    parameter int MAX_BLOCKS = lbcw_pkg::DEF_MAX_BLOCKS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lbcw_pkg::t_in              i_cmd,
    output logic                       o_res_valid,
    output lbcw_pkg::t_out             o_res,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lbcw_pkg::CFG_W-1:0] i_cfg_data
);
    import lbcw_pkg::*;

    localparam int LIM_W = $clog2(MAX_BLOCKS + 2);

    typedef enum logic [0:0] {S_IDLE, S_RUN} t_state;

    t_state           r_state;
    logic [CFG_W-1:0] r_cfg_cap;
    logic [TAG_W-1:0] r_key;
    logic             r_op;
    logic             r_last;
    logic [LIM_W-1:0] r_lim;
    logic [LIM_W-1:0] r_occ;
    t_wave            r_inj;
    logic             r_wave_done;
    logic             r_hit;
    logic             r_hdirty;
    logic             r_wbv;
    logic [TAG_W-1:0] r_wbtag;
    logic [CNT_W-1:0] r_read_hits;
    logic [CNT_W-1:0] r_write_hits;
    logic [CNT_W-1:0] r_cache_writes;
    logic             r_res_valid;
    t_out             r_res;

    t_wave            w_wave [0:MAX_BLOCKS];
    t_wave            w_exit;
    t_cmd             w_cmd;
    logic             w_accept;
    logic             w_fin;
    logic             w_mod_done;
    logic [CFG_W-1:0] w_rem;
    logic [CFG_W-1:0] w_cap;
    logic [LIM_W-1:0] w_cap_l;
    logic [LIM_W-1:0] w_occ_inc;
    logic [LIM_W-1:0] n_lim;
    logic [CNT_W-1:0] n_read_hits;
    logic [CNT_W-1:0] n_write_hits;
    logic [CNT_W-1:0] n_cache_writes;
    logic             n_wbv;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign w_accept    = start && !busy;
    assign w_fin       = (r_state == S_RUN) && r_wave_done && w_mod_done;

    always_comb begin
        if (r_cfg_cap == '0) begin
            w_cap = CFG_W'(1);
        end else if (32'(r_cfg_cap) > 32'(MAX_BLOCKS)) begin
            w_cap = CFG_W'(MAX_BLOCKS);
        end else begin
            w_cap = r_cfg_cap;
        end
    end

    assign w_cap_l   = LIM_W'(w_cap);
    assign w_occ_inc = r_occ + 1'b1;
    assign n_lim     = (w_occ_inc < w_cap_l) ? w_occ_inc : w_cap_l;

    assign n_read_hits    = r_read_hits + CNT_W'(r_hit && !r_op);
    assign n_write_hits   = r_write_hits + CNT_W'(r_hit && r_op);
    assign n_cache_writes = r_cache_writes + CNT_W'(!r_hit || r_op);
    assign n_wbv          = !r_hit && r_wbv;

    assign w_cmd.key       = r_key;
    assign w_cmd.fix_en    = w_fin && r_hit;
    assign w_cmd.fix_dirty = r_hdirty;
    assign w_cmd.trunc_en  = w_fin && !r_hit;

    assign w_wave[0] = r_inj;
    assign w_exit    = w_wave[MAX_BLOCKS];

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++) begin : g_chain
            lbcw_cell #(
                .MAX_BLOCKS (MAX_BLOCKS),
                .IDX        (g)
            ) u_node (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_wave  (w_wave[g]),
                .i_cmd   (w_cmd),
                .i_lim   (r_lim),
                .o_wave  (w_wave[g+1])
            );
        end
    endgenerate

    lbcw_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (i_cmd.block_number),
        .i_divisor  (w_cap),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cap <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_key          <= '0;
            r_op           <= 1'b0;
            r_last         <= 1'b0;
            r_lim          <= '0;
            r_occ          <= '0;
            r_inj          <= '0;
            r_wave_done    <= 1'b0;
            r_hit          <= 1'b0;
            r_hdirty       <= 1'b0;
            r_wbv          <= 1'b0;
            r_wbtag        <= '0;
            r_read_hits    <= '0;
            r_write_hits   <= '0;
            r_cache_writes <= '0;
            r_res_valid    <= 1'b0;
            r_res          <= '0;
        end else begin
            r_inj.act   <= w_accept;
            r_res_valid <= w_fin;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_key       <= i_cmd.block_number;
                        r_op        <= i_cmd.op;
                        r_last      <= i_cmd.last_block;
                        r_lim       <= n_lim;
                        r_inj.tag   <= i_cmd.block_number;
                        r_inj.dirty <= i_cmd.op;
                        r_wave_done <= 1'b0;
                        r_state     <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_exit.act) begin
                        r_wave_done <= 1'b1;
                        r_hit       <= w_exit.done && w_exit.hit;
                        r_hdirty    <= w_exit.hit_dirty;
                        r_wbv       <= w_exit.wb_valid;
                        r_wbtag     <= w_exit.wb_tag;
                    end
                    if (w_fin) begin
                        r_read_hits          <= n_read_hits;
                        r_write_hits         <= n_write_hits;
                        r_cache_writes       <= n_cache_writes;
                        r_res.hit            <= r_hit;
                        r_res.cache_slot     <= w_rem[SLOT_W-1:0];
                        r_res.cache_is_write <= !(r_hit && !r_op);
                        r_res.disk_fetch     <= !r_hit && !r_op;
                        r_res.writeback_valid <= n_wbv;
                        r_res.writeback_block <= n_wbv ? r_wbtag : '0;
                        r_res.read_hits      <= n_read_hits;
                        r_res.write_hits     <= n_write_hits;
                        r_res.cache_writes   <= n_cache_writes;
                        r_res.request_done   <= r_last;
                        if (!r_hit) begin
                            r_occ <= r_lim;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

@@ rtl/lbcw_checker.sv @@
module lbcw_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_res_valid,
    input lbcw_pkg::t_out             o_res,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready
);
    import lbcw_pkg::*;

`include "lru_block_cache_writeback_assert.svh"

    `LBCW_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "access not taken")
    `LBCW_ASSERT_NOW(a_res_idle, i_clk, i_rst_n, o_res_valid, !busy && o_cfg_ready, "result while busy")
    `LBCW_ASSERT_NEXT(a_res_pulse, i_clk, i_rst_n, o_res_valid, !o_res_valid, "result word repeated")
    `LBCW_ASSERT_NOW(a_wb_zero, i_clk, i_rst_n, o_res_valid && !o_res.writeback_valid, o_res.writeback_block == '0, "stale write-back block")
    `LBCW_ASSERT_NOW(a_fetch_miss, i_clk, i_rst_n, o_res_valid && o_res.disk_fetch, !o_res.hit && o_res.cache_is_write, "fetch on hit")

endmodule

bind lru_block_cache_writeback lbcw_checker u_checker (.*);

@@ sim/lru_block_cache_writeback_tb.sv @@
`timescale 1ns / 1ps

module lru_block_cache_writeback_tb;
    import lbcw_pkg::*;

    localparam int MAXB        = DEF_MAX_BLOCKS;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int TAIL_CYCLES = 300;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_in              i_cmd       = '0;
    logic             o_res_valid;
    t_out             o_res;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    logic [TAG_W-1:0] tag_mem   [MAXB];
    bit               valid_mem [MAXB];
    bit               dirty_mem [MAXB];
    int unsigned      lru_list  [MAXB];
    int unsigned      fill_count   = 0;
    logic [CNT_W-1:0] rd_hit_cnt   = '0;
    logic [CNT_W-1:0] wr_hit_cnt   = '0;
    logic [CNT_W-1:0] cache_wr_cnt = '0;
    logic [CFG_W-1:0] capacity_reg = CFG_RESET;

    t_out pending_results [$];
    int   error_count  = 0;
    int   result_count = 0;
    int   cycle_count  = 0;
    bit   no_idle      = 1'b0;

    lru_block_cache_writeback #(
        .MAX_BLOCKS(MAXB)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned eff_capacity(logic [CFG_W-1:0] c);
        int unsigned v;
        v = 32'(c);
        if (v < 1) v = 1;
        if (v > MAXB) v = MAXB;
        return v;
    endfunction

    function automatic void promote_entry(int unsigned pos);
        int unsigned e;
        e = lru_list[pos];
        for (int unsigned p = pos; p > 0; p--) lru_list[p] = lru_list[p-1];
        lru_list[0] = e;
    endfunction

    task automatic predict_access(input t_in a);
        t_out        r;
        int unsigned cap;
        int unsigned pos;
        int unsigned ent;
        int unsigned fresh;
        bit          found;
        bit          got_free;
        cap   = eff_capacity(capacity_reg);
        r     = '0;
        found = 1'b0;
        pos   = 0;
        while (pos < fill_count && !found) begin
            ent = lru_list[pos];
            if (valid_mem[ent] && tag_mem[ent] == a.block_number) found = 1'b1;
            else pos++;
        end
        if (found) begin
            promote_entry(pos);
            if (a.op) begin
                wr_hit_cnt   = wr_hit_cnt + 1'b1;
                cache_wr_cnt = cache_wr_cnt + 1'b1;
            end else begin
                rd_hit_cnt = rd_hit_cnt + 1'b1;
            end
        end else begin
            cache_wr_cnt = cache_wr_cnt + 1'b1;
            while (fill_count > 0 && fill_count + 1 > cap) begin
                ent = lru_list[fill_count-1];
                if (dirty_mem[ent] && !r.writeback_valid) begin
                    r.writeback_valid = 1'b1;
                    r.writeback_block = tag_mem[ent];
                end
                valid_mem[ent] = 1'b0;
                dirty_mem[ent] = 1'b0;
                fill_count--;
            end
            fresh    = 0;
            got_free = 1'b0;
            for (int i = 0; i < MAXB; i++) begin
                if (!got_free && !valid_mem[i]) begin
                    fresh    = i;
                    got_free = 1'b1;
                end
            end
            tag_mem[fresh]       = a.block_number;
            valid_mem[fresh]     = 1'b1;
            dirty_mem[fresh]     = a.op;
            lru_list[fill_count] = fresh;
            promote_entry(fill_count);
            fill_count++;
        end
        r.hit            = found;
        r.cache_slot     = SLOT_W'(a.block_number % cap);
        r.cache_is_write = !(found && !a.op);
        r.disk_fetch     = !found && !a.op;
        r.read_hits      = rd_hit_cnt;
        r.write_hits     = wr_hit_cnt;
        r.cache_writes   = cache_wr_cnt;
        r.request_done   = a.last_block;
        pending_results.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR result %0d: %s", result_count, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_res_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with no access pending");
            end else begin
                want = pending_results.pop_front();
                check_field("hit", 32'(o_res.hit), 32'(want.hit));
                check_field("cache_slot", 32'(o_res.cache_slot), 32'(want.cache_slot));
                check_field("cache_is_write", 32'(o_res.cache_is_write),
                            32'(want.cache_is_write));
                check_field("disk_fetch", 32'(o_res.disk_fetch), 32'(want.disk_fetch));
                check_field("writeback_valid", 32'(o_res.writeback_valid),
                            32'(want.writeback_valid));
                check_field("writeback_block", o_res.writeback_block, want.writeback_block);
                check_field("read_hits", o_res.read_hits, want.read_hits);
                check_field("write_hits", o_res.write_hits, want.write_hits);
                check_field("cache_writes", o_res.cache_writes, want.cache_writes);
                check_field("request_done", 32'(o_res.request_done),
                            32'(want.request_done));
            end
            result_count++;
        end
    end

    task automatic send_access(input logic op, input logic [TAG_W-1:0] blk,
                               input logic last);
        int  gap;
        t_in word;
        gap               = no_idle ? 0 : $urandom_range(0, 6);
        word.op           = op;
        word.block_number = blk;
        word.last_block   = last;
        if (gap > 0) begin
            start <= 1'b0;
            do @(posedge i_clk); while (busy !== 1'b0);
            repeat (gap - 1) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= word;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_access(word);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat ($urandom_range(0, 6)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        capacity_reg = value;
    endtask

    function automatic logic [TAG_W-1:0] draw_block(int unsigned pool,
                                                    logic [TAG_W-1:0] base);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return base + $urandom_range(0, pool - 1);
        else if (r < 90) return $urandom_range(0, 511);
        return $urandom;
    endfunction

    task automatic test_basic_access;
        send_access(1'b0, 32'h0000_0000, 1'b0);
        send_access(1'b1, 32'h0000_0000, 1'b1);
        send_access(1'b0, 32'h0000_0000, 1'b0);
        send_access(1'b1, 32'hFFFF_FFFF, 1'b0);
        send_access(1'b0, 32'hFFFF_FFFF, 1'b1);
        send_access(1'b0, 32'h8000_0001, 1'b1);
    endtask

    task automatic test_capacity_extremes;
        write_capacity(9'd0);
        send_access(1'b1, 32'd7, 1'b1);
        send_access(1'b1, 32'd8, 1'b0);
        send_access(1'b0, 32'd9, 1'b0);
        send_access(1'b0, 32'd10, 1'b1);
        send_access(1'b1, 32'd10, 1'b1);
        write_capacity(9'd511);
        send_access(1'b1, 32'd511, 1'b0);
        send_access(1'b0, 32'd256, 1'b1);
        send_access(1'b0, 32'd511, 1'b1);
    endtask

    task automatic test_capacity_shrink;
        write_capacity(9'd256);
        for (int i = 0; i < 8; i++) send_access(i[0], 32'd1000 + i, i == 7);
        write_capacity(9'd3);
        send_access(1'b0, 32'd2000, 1'b1);
        send_access(1'b0, 32'd1007, 1'b0);
        send_access(1'b1, 32'd1006, 1'b1);
    endtask

    task automatic test_random_requests;
        logic [CFG_W-1:0] phase_caps [10];
        int unsigned      pool;
        logic [TAG_W-1:0] base;
        logic [TAG_W-1:0] blk;
        logic             op;
        int               len;
        int               sent;
        phase_caps = '{9'd2, 9'd4, 9'd16, 9'd255, 9'd256, 9'd1, 9'd511, 9'd100, 9'd0, 9'd7};
        for (int ph = 0; ph < 10; ph++) begin
            write_capacity(phase_caps[ph]);
            pool    = eff_capacity(phase_caps[ph]);
            pool    = pool + pool / 2 + 2;
            base    = ph[0] ? $urandom : '0;
            no_idle = (ph % 4 == 3);
            sent    = 0;
            while (sent < 80) begin
                len = $urandom_range(1, 4);
                op  = 1'($urandom_range(0, 1));
                blk = draw_block(pool, base);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_access(1'($urandom_range(0, 1)), draw_block(pool, base),
                                    1'($urandom_range(0, 1)));
                    else
                        send_access(op, blk + k, k == len - 1);
                    sent++;
                end
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_access;
        test_capacity_extremes;
        test_capacity_shrink;
        test_random_requests;
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("lru_block_cache_writeback_tb passed");
        end else begin
            $display("lru_block_cache_writeback_tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("lru_block_cache_writeback_tb failed");
        $finish;
    end

endmodule
